@@ src/msld_pkg.sv @@
// shared types, codes and helpers of the message list store
package msld_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int NAME_CHARS      = 6;
   localparam int NAME_W          = 48;
   localparam int NAME_BYTES      = NAME_W / 8;
   localparam int ID_W            = 16;
   localparam int HOPS_W          = 8;
   localparam int STATUS_W        = 8;
   localparam int TAG_W           = 16;
   localparam int SLOT_W          = 8;
   localparam int MODE_W          = 3;
   localparam int OUTCOME_W       = 2;
   localparam int COUNT_W         = 7;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 48;

   // operation codes of a request
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MARK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STATUS = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUTCOME_DONE = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_DUP  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_NONE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LIST_ROLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEEP_ENABLE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEF_SENDER   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEF_RECIPIENT = 2'd3;

   localparam logic [NAME_W-1:0] DEF_SENDER_RESET    = 48'd827020885;
   localparam logic [NAME_W-1:0] DEF_RECIPIENT_RESET = 48'd5000257;

   // stored status codes
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 8'd0;
   localparam logic [STATUS_W-1:0] STATUS_PENDING = 8'd1;

   // cell operations
   localparam logic [2:0] CELL_HOLD       = 3'd0;
   localparam logic [2:0] CELL_LOAD_LEFT  = 3'd1;
   localparam logic [2:0] CELL_LOAD_RIGHT = 3'd2;
   localparam logic [2:0] CELL_CLR_UNREAD = 3'd3;
   localparam logic [2:0] CELL_SET_STATUS = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]     ident;
      logic [NAME_W-1:0]   sender;
      logic [NAME_W-1:0]   recipient;
      logic [HOPS_W-1:0]   hops_start;
      logic [HOPS_W-1:0]   hops_left;
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    text_tag;
   } msg_data_type;

   typedef struct packed {
      logic         valid;
      logic         unread;
      msg_data_type data;
   } entry_type;

   typedef struct packed {
      logic [2:0]          op;
      logic [STATUS_W-1:0] new_status;
   } cell_ctrl_type;

   typedef struct packed {
      logic [ID_W-1:0]   ident;
      logic [NAME_W-1:0] sender;
   } match_key_type;

   typedef struct packed {
      logic valid;
      logic dup_hit;
      logic id_hit;
      logic unread_live;
   } cell_stat_type;

   // keep characters up to the first zero byte, at most NAME_CHARS of them
   function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] v);
      logic [NAME_W-1:0] r;
      logic              stop;
      r    = '0;
      stop = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (i < NAME_CHARS && !stop) begin
            if (v[8*i +: 8] == 8'd0) begin
               stop = 1'b1;
            end else begin
               r[8*i +: 8] = v[8*i +: 8];
            end
         end
      end
      return r;
   endfunction

endpackage

@@ src/msld_cell.sv @@
// one slot of the message table with its own comparators
module msld_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  msld_pkg::entry_type     left_in,
   input  msld_pkg::entry_type     right_in,
   input  msld_pkg::cell_ctrl_type ctrl,
   input  msld_pkg::match_key_type key,
   output msld_pkg::entry_type     entry_out,
   output msld_pkg::cell_stat_type stat
);

   logic                   valid_ff,  valid_in;
   logic                   unread_ff, unread_in;
   msld_pkg::msg_data_type data_ff,   data_in;

   always_comb begin
      valid_in  = valid_ff;
      unread_in = unread_ff;
      data_in   = data_ff;
      case (ctrl.op)
         msld_pkg::CELL_LOAD_LEFT: begin
            valid_in  = left_in.valid;
            unread_in = left_in.unread;
            data_in   = left_in.data;
         end
         msld_pkg::CELL_LOAD_RIGHT: begin
            valid_in  = right_in.valid;
            unread_in = right_in.unread;
            data_in   = right_in.data;
         end
         msld_pkg::CELL_CLR_UNREAD: begin
            unread_in = 1'b0;
         end
         msld_pkg::CELL_SET_STATUS: begin
            data_in.status = ctrl.new_status;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         unread_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         unread_ff <= unread_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry_out.valid  = valid_ff;
   assign entry_out.unread = unread_ff;
   assign entry_out.data   = data_ff;

   assign stat.valid       = valid_ff;
   assign stat.id_hit      = valid_ff && (data_ff.ident == key.ident);
   assign stat.dup_hit     = valid_ff && (data_ff.ident == key.ident)
                             && (data_ff.sender == key.sender);
   assign stat.unread_live = valid_ff && unread_ff;

endmodule

@@ src/message_list_store_with_dedup_top.sv @@
// top level of the newest-first message table with duplicate drop
// ---------------------------------------------------------------------------
// newest-first message table of ENTRIES slots, built as a row of cells that
// each hold one entry and compare it against the request on their own. an
// add shifts every cell one place towards the end (the oldest falls off) and
// loads the new entry into slot 0; a delete pulls every cell at or after the
// slot one place back and clears the last one. in inbox role an add whose
// nonzero id and sender match a valid entry is dropped with outcome 1. empty
// names are replaced by the configured defaults, cut to NAME_CHARS
// characters. one transaction is handled at a time: names are trimmed and the
// request captured at acceptance, then the cell update is registered, then
// the unread summary and the count are registered into the result registers
// and the result is offered; the next request is taken in the cycle after
// the result is taken, so a transaction is also held up by every cycle that
// rsp_stall holds the result. the user must write the csr port only while no
// transaction is in flight; the block itself does not enforce this. valid
// entries always form a prefix of the table, so the entry count is kept in a
// counter of its own
// ---------------------------------------------------------------------------
module message_list_store_with_dedup_top #(
   parameter int ENTRIES = msld_pkg::ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [msld_pkg::MODE_W-1:0]         req_mode,
   input  logic [msld_pkg::ID_W-1:0]           req_msg_id,
   input  logic [msld_pkg::NAME_W-1:0]         req_sender,
   input  logic [msld_pkg::NAME_W-1:0]         req_recipient,
   input  logic [msld_pkg::HOPS_W-1:0]         req_hops_start,
   input  logic [msld_pkg::HOPS_W-1:0]         req_hops_left,
   input  logic                                req_is_unread,
   input  logic [msld_pkg::TAG_W-1:0]          req_text_tag,
   input  logic [msld_pkg::SLOT_W-1:0]         req_slot,
   input  logic [msld_pkg::STATUS_W-1:0]       req_new_status,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [msld_pkg::OUTCOME_W-1:0]      rsp_outcome,
   output logic [msld_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic                                rsp_any_unread,
   output logic                                rsp_beep_request,
   output logic                                rsp_display_refresh,
   // configuration port
   input  logic                                csr_write,
   input  logic [msld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [msld_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int SW    = msld_pkg::SLOT_W + 1;

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff, state_in;

   // configuration registers
   logic                          role_ff;
   logic                          beep_en_ff;
   logic [msld_pkg::NAME_W-1:0]   def_sender_ff;
   logic [msld_pkg::NAME_W-1:0]   def_recipient_ff;

   // captured transaction
   logic [msld_pkg::MODE_W-1:0]   mode_ff;
   logic [msld_pkg::SLOT_W-1:0]   slot_ff;
   logic [msld_pkg::STATUS_W-1:0] new_status_ff;
   msld_pkg::entry_type           new_entry_ff, new_entry_in;

   logic [CNT_W-1:0]              count_ff, count_in;

   // result registers
   logic                          rsp_valid_ff;
   logic [msld_pkg::OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic                          beep_ff, beep_in;
   logic                          refresh_ff, refresh_in;
   logic                          any_unread_ff;
   logic [msld_pkg::COUNT_W-1:0]  count_out_ff;

   // cell row
   msld_pkg::entry_type           cell_entry [ENTRIES];
   msld_pkg::cell_stat_type       cell_stat  [ENTRIES];
   msld_pkg::cell_ctrl_type       cell_ctrl  [ENTRIES];
   msld_pkg::match_key_type       key;

   logic [ENTRIES-1:0]            dup_vec;
   logic [ENTRIES-1:0]            id_vec;
   logic [ENTRIES-1:0]            first_id;
   logic [ENTRIES-1:0]            unread_vec;

   logic                          req_take;
   logic                          rsp_take;
   logic                          dup;
   logic                          del_ok;
   logic                          slot_in_range;
   logic [msld_pkg::NAME_W-1:0]   snd_trim, rcp_trim;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff          <= 1'b0;
         beep_en_ff       <= 1'b1;
         def_sender_ff    <= msld_pkg::DEF_SENDER_RESET;
         def_recipient_ff <= msld_pkg::DEF_RECIPIENT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            msld_pkg::CSR_LIST_ROLE:     role_ff          <= csr_wdata[0];
            msld_pkg::CSR_BEEP_ENABLE:   beep_en_ff       <= csr_wdata[0];
            msld_pkg::CSR_DEF_SENDER:    def_sender_ff    <= csr_wdata;
            msld_pkg::CSR_DEF_RECIPIENT: def_recipient_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---------------- capture: trim names and build the new entry ----------------
   always_comb begin
      snd_trim = msld_pkg::trim_name(req_sender);
      if (snd_trim == '0) begin
         snd_trim = msld_pkg::trim_name(def_sender_ff);
      end
      rcp_trim = msld_pkg::trim_name(req_recipient);
      if (rcp_trim == '0) begin
         rcp_trim = msld_pkg::trim_name(def_recipient_ff);
      end
      new_entry_in.valid           = 1'b1;
      // outbox entries are never unread
      new_entry_in.unread          = !role_ff && req_is_unread;
      new_entry_in.data.ident      = req_msg_id;
      new_entry_in.data.sender     = snd_trim;
      new_entry_in.data.recipient  = rcp_trim;
      new_entry_in.data.hops_start = req_hops_start;
      new_entry_in.data.hops_left  = req_hops_left;
      new_entry_in.data.status     = role_ff ? msld_pkg::STATUS_PENDING
                                             : msld_pkg::STATUS_NONE;
      new_entry_in.data.text_tag   = req_text_tag;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff       <= req_mode;
         slot_ff       <= req_slot;
         new_status_ff <= req_new_status;
         new_entry_ff  <= new_entry_in;
      end
   end

   // ---------------- cell row ----------------
   assign key.ident  = new_entry_ff.data.ident;
   assign key.sender = new_entry_ff.data.sender;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         msld_pkg::entry_type left_e, right_e;
         if (g == 0) begin : g_head
            assign left_e = new_entry_ff;
         end else begin : g_mid
            assign left_e = cell_entry[g-1];
         end
         if (g == ENTRIES - 1) begin : g_tail
            // the last slot is cleared when the table compacts
            assign right_e = '0;
         end else begin : g_body
            assign right_e = cell_entry[g+1];
         end

         msld_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .left_in   (left_e),
            .right_in  (right_e),
            .ctrl      (cell_ctrl[g]),
            .key       (key),
            .entry_out (cell_entry[g]),
            .stat      (cell_stat[g])
         );

         assign dup_vec[g]    = cell_stat[g].dup_hit;
         assign id_vec[g]     = cell_stat[g].id_hit;
         assign unread_vec[g] = cell_stat[g].unread_live;
      end
   endgenerate

   // lowest matching slot wins for a status update
   assign first_id = id_vec & (~id_vec + ENTRIES'(1));

   // an id of zero never counts as a duplicate, and the outbox never checks
   assign dup           = !role_ff && (key.ident != '0) && (|dup_vec);
   assign slot_in_range = {1'b0, slot_ff} < SW'(ENTRIES);
   // valid entries form a prefix, so a slot below the count is occupied
   assign del_ok        = {1'b0, slot_ff} < SW'(count_ff);

   // ---------------- execute: decide the operation of every cell ----------------
   always_comb begin
      outcome_in = msld_pkg::OUTCOME_NONE;
      beep_in    = 1'b0;
      refresh_in = 1'b0;
      count_in   = count_ff;
      for (int k = 0; k < ENTRIES; k++) begin
         cell_ctrl[k].op         = msld_pkg::CELL_HOLD;
         cell_ctrl[k].new_status = new_status_ff;
      end
      if (state_ff == ST_EXEC) begin
         case (mode_ff)
            msld_pkg::MODE_ADD: begin
               if (dup) begin
                  outcome_in = msld_pkg::OUTCOME_DUP;
               end else begin
                  for (int k = 0; k < ENTRIES; k++) begin
                     cell_ctrl[k].op = msld_pkg::CELL_LOAD_LEFT;
                  end
                  outcome_in = msld_pkg::OUTCOME_DONE;
                  refresh_in = 1'b1;
                  beep_in    = new_entry_ff.unread && beep_en_ff;
                  count_in   = count_ff + CNT_W'(count_ff != CNT_W'(ENTRIES));
               end
            end
            msld_pkg::MODE_DELETE: begin
               if (del_ok) begin
                  for (int k = 0; k < ENTRIES; k++) begin
                     if (SW'(k) >= {1'b0, slot_ff}) begin
                        cell_ctrl[k].op = msld_pkg::CELL_LOAD_RIGHT;
                     end
                  end
                  outcome_in = msld_pkg::OUTCOME_DONE;
                  refresh_in = 1'b1;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            msld_pkg::MODE_MARK: begin
               // also clears the flag of an empty slot
               if (slot_in_range) begin
                  for (int k = 0; k < ENTRIES; k++) begin
                     if (SW'(k) == {1'b0, slot_ff}) begin
                        cell_ctrl[k].op = msld_pkg::CELL_CLR_UNREAD;
                     end
                  end
                  outcome_in = msld_pkg::OUTCOME_DONE;
                  refresh_in = 1'b1;
               end
            end
            msld_pkg::MODE_STATUS: begin
               if (|id_vec) begin
                  for (int k = 0; k < ENTRIES; k++) begin
                     if (first_id[k]) begin
                        cell_ctrl[k].op = msld_pkg::CELL_SET_STATUS;
                     end
                  end
                  outcome_in = msld_pkg::OUTCOME_DONE;
                  refresh_in = 1'b1;
               end
            end
            msld_pkg::MODE_QUERY: begin
               outcome_in = msld_pkg::OUTCOME_DONE;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_SUM;
         ST_SUM:  state_in = ST_RESP;
         ST_RESP: if (rsp_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_SUM) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload: outcome flags at the cell update, summary in the following cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         outcome_ff <= outcome_in;
         beep_ff    <= beep_in;
         refresh_ff <= refresh_in;
      end
      if (state_ff == ST_SUM) begin
         any_unread_ff <= |unread_vec;
         count_out_ff  <= msld_pkg::COUNT_W'(count_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = outcome_ff;
   assign rsp_entry_count     = count_out_ff;
   assign rsp_any_unread      = any_unread_ff;
   assign rsp_beep_request    = beep_ff;
   assign rsp_display_refresh = refresh_ff;

endmodule

@@ src/msld_checker.sv @@
// port-level checks of the message list store, bound to the top level
module msld_checker #(
   parameter int ENTRIES = msld_pkg::ENTRIES_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [msld_pkg::OUTCOME_W-1:0]      rsp_outcome,
   input logic [msld_pkg::COUNT_W-1:0]        rsp_entry_count,
   input logic                                rsp_beep_request,
   input logic                                rsp_display_refresh
);

   // count never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= msld_pkg::COUNT_W'(ENTRIES)))
      else $error("entry count above table depth");

   // a beep only comes with a stored add
   a_beep_stored: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beep_request) |->
         (rsp_outcome == msld_pkg::OUTCOME_DONE && rsp_display_refresh))
      else $error("beep without a stored entry");

   // a dropped duplicate changes nothing
   a_dup_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == msld_pkg::OUTCOME_DUP) |->
         (!rsp_display_refresh && !rsp_beep_request))
      else $error("duplicate drop reported a change");

   // one transaction at a time: busy right after acceptance
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a transaction is in flight");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_entry_count)))
      else $error("stalled result changed");

endmodule

bind message_list_store_with_dedup_top msld_checker #(.ENTRIES(ENTRIES)) u_msld_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_outcome         (rsp_outcome),
   .rsp_entry_count     (rsp_entry_count),
   .rsp_beep_request    (rsp_beep_request),
   .rsp_display_refresh (rsp_display_refresh)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the newest-first message table with duplicate drop
module testbench;

   localparam int ROWS  = msld_pkg::ENTRIES_DEFAULT;
   localparam int ROW_W = $clog2(ROWS);
   localparam int LIMIT = 200000;

   localparam logic ROLE_INBOX  = 1'b0;
   localparam logic ROLE_OUTBOX = 1'b1;

   // mode codes the block does not define
   localparam logic [msld_pkg::MODE_W-1:0] MODE_FIRST_UNUSED = msld_pkg::MODE_QUERY + 3'd1;
   localparam logic [msld_pkg::MODE_W-1:0] MODE_LAST_UNUSED  = '1;

   // short names, none longer than four characters, so junk after the end is cut off by trimming
   localparam logic [msld_pkg::NAME_W-1:0] NAME_POOL [4] = '{
      48'h0000_0000_4F42, 48'h0000_4E41_4D52, 48'h0000_0058_5A51, 48'h0000_0000_0043
   };

   typedef struct packed {
      logic [msld_pkg::MODE_W-1:0]   mode;
      logic [msld_pkg::ID_W-1:0]     msg_id;
      logic [msld_pkg::NAME_W-1:0]   sender;
      logic [msld_pkg::NAME_W-1:0]   recipient;
      logic [msld_pkg::HOPS_W-1:0]   hops_start;
      logic [msld_pkg::HOPS_W-1:0]   hops_left;
      logic                          is_unread;
      logic [msld_pkg::TAG_W-1:0]    text_tag;
      logic [msld_pkg::SLOT_W-1:0]   slot;
      logic [msld_pkg::STATUS_W-1:0] new_status;
   } request_type;

   typedef struct packed {
      logic [msld_pkg::OUTCOME_W-1:0] outcome;
      logic [msld_pkg::COUNT_W-1:0]   count;
      logic                           any_unread;
      logic                           beep;
      logic                           refresh;
   } result_type;

   typedef struct packed {
      logic                          valid;
      logic                          unread;
      logic [msld_pkg::ID_W-1:0]     ident;
      logic [msld_pkg::NAME_W-1:0]   sender;
      logic [msld_pkg::NAME_W-1:0]   recipient;
      logic [msld_pkg::HOPS_W-1:0]   hops_start;
      logic [msld_pkg::HOPS_W-1:0]   hops_left;
      logic [msld_pkg::STATUS_W-1:0] status;
      logic [msld_pkg::TAG_W-1:0]    text_tag;
   } stored_msg_type;

   // mirror of the message list plus the queue of results still owed by the block
   class msg_list_board;
      logic                        role;
      logic                        beep_on;
      logic [msld_pkg::NAME_W-1:0] dflt_sender;
      logic [msld_pkg::NAME_W-1:0] dflt_recipient;
      stored_msg_type              rows [ROWS];
      result_type                  awaited [$];
      int errors, checked, stored_adds, dup_drops, no_effect;

      function new();
         role           = ROLE_INBOX;
         beep_on        = 1'b1;
         dflt_sender    = msld_pkg::DEF_SENDER_RESET;
         dflt_recipient = msld_pkg::DEF_RECIPIENT_RESET;
         foreach (rows[k]) rows[k] = '0;
      endfunction

      function void set_register(logic [msld_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [msld_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            msld_pkg::CSR_LIST_ROLE:     role = value[0];
            msld_pkg::CSR_BEEP_ENABLE:   beep_on = value[0];
            msld_pkg::CSR_DEF_SENDER:    dflt_sender = value;
            msld_pkg::CSR_DEF_RECIPIENT: dflt_recipient = value;
            default: ;
         endcase
      endfunction

      // characters up to the first zero byte, at most NAME_CHARS of them
      function logic [msld_pkg::NAME_W-1:0] cut_name(logic [msld_pkg::NAME_W-1:0] v);
         logic [msld_pkg::NAME_W-1:0] r;
         logic                        ended;
         r     = '0;
         ended = 1'b0;
         for (int i = 0; i < msld_pkg::NAME_CHARS && i < msld_pkg::NAME_BYTES; i++) begin
            if (v[8*i +: 8] == 8'h00) ended = 1'b1;
            if (!ended) r[8*i +: 8] = v[8*i +: 8];
         end
         return r;
      endfunction

      function logic [msld_pkg::NAME_W-1:0] name_or_fallback(
            logic [msld_pkg::NAME_W-1:0] v, logic [msld_pkg::NAME_W-1:0] fallback);
         logic [msld_pkg::NAME_W-1:0] t;
         t = cut_name(v);
         return (t != '0) ? t : cut_name(fallback);
      endfunction

      // apply one accepted request to the mirror and queue the result it owes
      function void note_request(request_type r);
         result_type                  res;
         logic [msld_pkg::NAME_W-1:0] snd;
         logic                        dup;
         logic                        unr;
         stored_msg_type              fresh;
         int                          hit;
         res         = '0;
         res.outcome = msld_pkg::OUTCOME_NONE;
         dup         = 1'b0;
         hit         = -1;
         case (r.mode)
            msld_pkg::MODE_ADD: begin
               snd = name_or_fallback(r.sender, dflt_sender);
               if (role == ROLE_INBOX && r.msg_id != '0)
                  foreach (rows[k])
                     if (rows[k].valid && rows[k].ident == r.msg_id && rows[k].sender == snd)
                        dup = 1'b1;
               if (dup) begin
                  res.outcome = msld_pkg::OUTCOME_DUP;
                  dup_drops++;
               end else begin
                  unr = (role == ROLE_INBOX) && r.is_unread;
                  for (int k = ROWS - 1; k > 0; k--) rows[k] = rows[k-1];
                  fresh            = '0;
                  fresh.valid      = 1'b1;
                  fresh.unread     = unr;
                  fresh.ident      = r.msg_id;
                  fresh.sender     = snd;
                  fresh.recipient  = name_or_fallback(r.recipient, dflt_recipient);
                  fresh.hops_start = r.hops_start;
                  fresh.hops_left  = r.hops_left;
                  fresh.status     = (role == ROLE_OUTBOX) ? msld_pkg::STATUS_PENDING
                                                           : msld_pkg::STATUS_NONE;
                  fresh.text_tag   = r.text_tag;
                  rows[0]          = fresh;
                  res.outcome      = msld_pkg::OUTCOME_DONE;
                  res.refresh      = 1'b1;
                  res.beep         = unr && beep_on;
                  stored_adds++;
               end
            end
            msld_pkg::MODE_DELETE: begin
               if (r.slot < ROWS && rows[r.slot[ROW_W-1:0]].valid) begin
                  for (int k = int'(r.slot); k < ROWS - 1; k++) rows[k] = rows[k+1];
                  rows[ROWS-1] = '0;
                  res.outcome  = msld_pkg::OUTCOME_DONE;
                  res.refresh  = 1'b1;
               end
            end
            msld_pkg::MODE_MARK: begin
               if (r.slot < ROWS) begin
                  rows[r.slot[ROW_W-1:0]].unread = 1'b0;
                  res.outcome = msld_pkg::OUTCOME_DONE;
                  res.refresh = 1'b1;
               end
            end
            msld_pkg::MODE_STATUS: begin
               foreach (rows[k])
                  if (hit < 0 && rows[k].valid && rows[k].ident == r.msg_id) hit = k;
               if (hit >= 0) begin
                  rows[hit].status = r.new_status;
                  res.outcome      = msld_pkg::OUTCOME_DONE;
                  res.refresh      = 1'b1;
               end
            end
            msld_pkg::MODE_QUERY: res.outcome = msld_pkg::OUTCOME_DONE;
            default: ;
         endcase
         foreach (rows[k])
            if (rows[k].valid) begin
               res.count++;
               if (rows[k].unread) res.any_unread = 1'b1;
            end
         if (res.outcome == msld_pkg::OUTCOME_NONE) no_effect++;
         awaited.push_back(res);
      endfunction

      task report(string what, logic [63:0] seen, logic [63:0] wanted);
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, seen, wanted);
         errors++;
      endtask

      task check_result(result_type got);
         result_type want;
         if (awaited.size() == 0) begin
            report("result with nothing outstanding", 64'(got), '0);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.outcome !== want.outcome)
            report("outcome", 64'(got.outcome), 64'(want.outcome));
         if (got.count !== want.count)
            report("entry_count", 64'(got.count), 64'(want.count));
         if (got.any_unread !== want.any_unread)
            report("any_unread", 64'(got.any_unread), 64'(want.any_unread));
         if (got.beep !== want.beep)
            report("beep_request", 64'(got.beep), 64'(want.beep));
         if (got.refresh !== want.refresh)
            report("display_refresh", 64'(got.refresh), 64'(want.refresh));
      endtask
   endclass

   // clock, reset and block ports; every input known from time zero
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [msld_pkg::MODE_W-1:0]      req_mode = '0;
   logic [msld_pkg::ID_W-1:0]        req_msg_id = '0;
   logic [msld_pkg::NAME_W-1:0]      req_sender = '0;
   logic [msld_pkg::NAME_W-1:0]      req_recipient = '0;
   logic [msld_pkg::HOPS_W-1:0]      req_hops_start = '0;
   logic [msld_pkg::HOPS_W-1:0]      req_hops_left = '0;
   logic                             req_is_unread = 1'b0;
   logic [msld_pkg::TAG_W-1:0]       req_text_tag = '0;
   logic [msld_pkg::SLOT_W-1:0]      req_slot = '0;
   logic [msld_pkg::STATUS_W-1:0]    req_new_status = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [msld_pkg::OUTCOME_W-1:0]   rsp_outcome;
   logic [msld_pkg::COUNT_W-1:0]     rsp_entry_count;
   logic                             rsp_any_unread;
   logic                             rsp_beep_request;
   logic                             rsp_display_refresh;
   logic                             csr_write = 1'b0;
   logic [msld_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [msld_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   msg_list_board board;
   result_type    seen_result;
   int            cycles = 0;
   int            sent = 0;
   int            settings_used = 1;
   logic          steady = 1'b0;   // set for the stretch where neither side idles

   message_list_store_with_dedup_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_msg_id          (req_msg_id),
      .req_sender          (req_sender),
      .req_recipient       (req_recipient),
      .req_hops_start      (req_hops_start),
      .req_hops_left       (req_hops_left),
      .req_is_unread       (req_is_unread),
      .req_text_tag        (req_text_tag),
      .req_slot            (req_slot),
      .req_new_status      (req_new_status),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_outcome         (rsp_outcome),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_any_unread      (rsp_any_unread),
      .rsp_beep_request    (rsp_beep_request),
      .rsp_display_refresh (rsp_display_refresh),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // idle about fifteen percent of the time, never during the steady stretch
   function automatic logic take_break();
      return !steady && ($urandom_range(99) < 15);
   endfunction

   // result side: stall decided at the falling edge, transaction taken at the rising edge
   always @(negedge clock) begin
      rsp_stall = take_break();
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.outcome    = rsp_outcome;
         seen_result.count      = rsp_entry_count;
         seen_result.any_unread = rsp_any_unread;
         seen_result.beep       = rsp_beep_request;
         seen_result.refresh    = rsp_display_refresh;
         board.check_result(seen_result);
      end
   end

   // present one request, hold it through any stall, and note it once taken;
   // valid stays high afterwards so back-to-back transactions need no gap
   task automatic send_request(input request_type r);
      @(negedge clock);
      while (take_break()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_mode       = r.mode;
      req_msg_id     = r.msg_id;
      req_sender     = r.sender;
      req_recipient  = r.recipient;
      req_hops_start = r.hops_start;
      req_hops_left  = r.hops_left;
      req_is_unread  = r.is_unread;
      req_text_tag   = r.text_tag;
      req_slot       = r.slot;
      req_new_status = r.new_status;
      req_valid      = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      sent++;
   endtask

   // drop valid and wait for every owed result, so the block is idle
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [msld_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [msld_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      board.set_register(idx, value);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [msld_pkg::NAME_W-1:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[msld_pkg::NAME_W-1:0];
   endfunction

   // mostly short names from a pool so duplicates come up often
   function automatic logic [msld_pkg::NAME_W-1:0] random_name();
      logic [msld_pkg::NAME_W-1:0] v;
      int                          cut;
      v   = rand48();
      cut = $urandom_range(msld_pkg::NAME_BYTES - 1);
      case ($urandom_range(9))
         0:             v = '0;
         1, 2, 3, 4, 5: v = NAME_POOL[$urandom_range(3)];
         6:             v[8*cut +: 8] = 8'h00;
         // pool name with junk beyond its end, trims to the plain pool name
         7:             v = NAME_POOL[$urandom_range(3)] | {v[7:0] | 8'h01, 40'h0};
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [msld_pkg::ID_W-1:0] random_id();
      case ($urandom_range(9))
         0:       return '0;
         8:       return '1;
         9:       return msld_pkg::ID_W'($urandom_range(65535));
         default: return msld_pkg::ID_W'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          pick;
      pick         = $urandom_range(99);
      r.msg_id     = random_id();
      r.sender     = random_name();
      r.recipient  = random_name();
      r.hops_start = msld_pkg::HOPS_W'($urandom_range(255));
      r.hops_left  = msld_pkg::HOPS_W'($urandom_range(255));
      r.is_unread  = 1'($urandom_range(1));
      r.text_tag   = msld_pkg::TAG_W'($urandom_range(65535));
      r.new_status = msld_pkg::STATUS_W'($urandom_range(255));
      r.slot       = ($urandom_range(9) < 8) ? msld_pkg::SLOT_W'($urandom_range(ROWS - 1))
                                             : msld_pkg::SLOT_W'($urandom_range(255));
      if (pick < 45)      r.mode = msld_pkg::MODE_ADD;
      else if (pick < 60) r.mode = msld_pkg::MODE_DELETE;
      else if (pick < 72) r.mode = msld_pkg::MODE_MARK;
      else if (pick < 84) r.mode = msld_pkg::MODE_STATUS;
      else if (pick < 92) r.mode = msld_pkg::MODE_QUERY;
      else r.mode = msld_pkg::MODE_W'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
      return r;
   endfunction

   function automatic request_type plain_request(input logic [msld_pkg::MODE_W-1:0] mode);
      request_type r;
      r      = '0;
      r.mode = mode;
      return r;
   endfunction

   initial begin
      request_type                 q;
      logic                        role_v;
      logic                        beep_v;
      logic [msld_pkg::NAME_W-1:0] snd_v;
      logic [msld_pkg::NAME_W-1:0] rcp_v;
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: operations on the empty list after reset
      q = plain_request(msld_pkg::MODE_QUERY);
      send_request(q);
      q.mode = msld_pkg::MODE_DELETE;   // empty slot, no effect
      send_request(q);
      q.mode = msld_pkg::MODE_MARK;     // in range, still counts as done
      send_request(q);
      q.slot = msld_pkg::SLOT_W'(ROWS); // first slot past the end
      send_request(q);
      q.slot = '1;
      send_request(q);
      q = plain_request(msld_pkg::MODE_STATUS);   // no id to match
      q.msg_id = 16'd1;
      send_request(q);

      // empty names take the defaults; id zero is never a duplicate
      q = plain_request(msld_pkg::MODE_ADD);
      q.is_unread = 1'b1;
      send_request(q);
      send_request(q);

      // all-ones fields, then the same id and sender again is dropped
      q.msg_id     = '1;
      q.sender     = '1;
      q.recipient  = '1;
      q.hops_start = '1;
      q.hops_left  = '1;
      q.text_tag   = '1;
      q.new_status = '1;
      q.slot       = '1;
      send_request(q);
      send_request(q);
      q.sender = 48'h0000_0000_5A5A;   // same id, other sender is kept
      send_request(q);

      // junk after the end of a name does not hide a duplicate
      q = plain_request(msld_pkg::MODE_ADD);
      q.msg_id = 16'd5;
      q.sender = 48'hFFFF_0000_4142;
      send_request(q);
      q.sender = 48'h0000_0000_4142;
      send_request(q);

      q = plain_request(msld_pkg::MODE_STATUS);
      q.msg_id     = '1;
      q.new_status = '1;
      send_request(q);
      q.msg_id     = '0;
      q.new_status = '0;
      send_request(q);
      q = plain_request(msld_pkg::MODE_MARK);
      send_request(q);
      q = plain_request(msld_pkg::MODE_DELETE);
      q.slot = msld_pkg::SLOT_W'(ROWS - 1);
      send_request(q);
      q.slot = '0;
      send_request(q);
      send_request(plain_request(MODE_FIRST_UNUSED));
      send_request(plain_request(MODE_LAST_UNUSED));

      // outbox role: no duplicate check, pending status, unread forced clear
      drain_results();
      write_register(msld_pkg::CSR_LIST_ROLE, {{(msld_pkg::CSR_DATA_W-1){1'b1}}, ROLE_OUTBOX});
      write_register(msld_pkg::CSR_BEEP_ENABLE, '0);
      write_register(msld_pkg::CSR_DEF_SENDER, '1);
      write_register(msld_pkg::CSR_DEF_RECIPIENT, '0);
      settings_used++;
      q = plain_request(msld_pkg::MODE_ADD);
      q.msg_id    = 16'd7;
      q.is_unread = 1'b1;
      send_request(q);
      send_request(q);
      q = plain_request(msld_pkg::MODE_STATUS);
      q.msg_id     = 16'd7;
      q.new_status = 8'd3;
      send_request(q);
      q = plain_request(msld_pkg::MODE_DELETE);
      q.slot = '1;
      send_request(q);
      send_request(plain_request(msld_pkg::MODE_QUERY));

      // random phases, each under its own register setting
      for (int p = 0; p < 6; p++) begin
         drain_results();
         snd_v = rand48();
         rcp_v = rand48();
         case (p)
            0: begin
               role_v = ROLE_INBOX;  beep_v = 1'b1; snd_v = '0; rcp_v = '1;
            end
            1: begin
               role_v = ROLE_OUTBOX; beep_v = 1'b0; snd_v = '1; rcp_v = '0;
            end
            2: begin
               role_v = ROLE_INBOX;  beep_v = 1'b0;
            end
            3: begin
               role_v = ROLE_OUTBOX; beep_v = 1'b1; snd_v[15:8] = 8'h00;
            end
            4: begin
               role_v = ROLE_INBOX;  beep_v = 1'b1;
               snd_v  = msld_pkg::DEF_SENDER_RESET;
               rcp_v  = msld_pkg::DEF_RECIPIENT_RESET;
            end
            default: begin
               role_v = ROLE_INBOX;  beep_v = 1'b1;
            end
         endcase
         // upper write data bits carry junk on the one-bit registers
         write_register(msld_pkg::CSR_LIST_ROLE,
                        msld_pkg::CSR_DATA_W'({rand48() >> 1, role_v}));
         write_register(msld_pkg::CSR_BEEP_ENABLE,
                        msld_pkg::CSR_DATA_W'({rand48() >> 1, beep_v}));
         write_register(msld_pkg::CSR_DEF_SENDER, snd_v);
         write_register(msld_pkg::CSR_DEF_RECIPIENT, rcp_v);
         settings_used++;
         steady = (p == 5);
         repeat (105) send_request(random_request());
      end
      steady = 1'b0;

      drain_results();
      repeat (10) @(posedge clock);
      $display("%0d transactions under %0d register settings, %0d results checked",
               sent, settings_used, board.checked);
      $display("%0d adds stored, %0d duplicates dropped, %0d with no effect",
               board.stored_adds, board.dup_drops, board.no_effect);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
